// ===== hdl/gba_pkg.sv =====
// Shared types, widths and codes for the gyro bias autocalibration heading block.
`timescale 1ns / 1ps
package gba_pkg;

   // Fixed-point format of rates and heading
   localparam int FRACTION_BITS = 16;
   localparam int RATE_SHIFT    = 24 - FRACTION_BITS;

   // Field and state widths
   localparam int OP_W     = 2;
   localparam int RAW_W    = 16;
   localparam int IVL_W    = 16;
   localparam int RATE_W   = 26;
   localparam int CORR_W   = 27;
   localparam int HEAD_W   = 32;
   localparam int VAR_W    = 36;
   localparam int COUNT_W  = 11;
   localparam int SCALE_W  = 24;
   localparam int WEIGHT_W = 16;
   localparam int LIMIT_W  = 24;

   // Shared multiplier: signed A x signed B
   localparam int MUL_A_W  = 38;
   localparam int MUL_B_W  = 18;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SQ_SPLIT = 13;

   // Stream packing
   localparam int REQ_DATA_W = RAW_W + IVL_W;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - CORR_W - HEAD_W;

   // Operation codes
   localparam logic [OP_W-1:0] OP_UPDATE    = 2'd0;
   localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_SCALE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAN_WEIGHT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_WEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_WEIGHT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE_LIMIT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_CEILING     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIBRATED_LEVEL = 3'd6;

   // Datapath step codes
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] CMD_IDLE       = 4'd0;
   localparam logic [STEP_W-1:0] CMD_MUL_RATE   = 4'd1;
   localparam logic [STEP_W-1:0] CMD_SET_RATE   = 4'd2;
   localparam logic [STEP_W-1:0] CMD_MUL_HEAD   = 4'd3;
   localparam logic [STEP_W-1:0] CMD_ADD_HEAD   = 4'd4;
   localparam logic [STEP_W-1:0] CMD_MUL_MEAN   = 4'd5;
   localparam logic [STEP_W-1:0] CMD_ADD_MEAN   = 4'd6;
   localparam logic [STEP_W-1:0] CMD_MUL_SQH    = 4'd7;
   localparam logic [STEP_W-1:0] CMD_MUL_SQL    = 4'd8;
   localparam logic [STEP_W-1:0] CMD_SUM_SQ     = 4'd9;
   localparam logic [STEP_W-1:0] CMD_MUL_VAR    = 4'd10;
   localparam logic [STEP_W-1:0] CMD_ADD_VAR    = 4'd11;
   localparam logic [STEP_W-1:0] CMD_MUL_BIAS   = 4'd12;
   localparam logic [STEP_W-1:0] CMD_ADD_BIAS   = 4'd13;
   localparam logic [STEP_W-1:0] CMD_CLEAR_HEAD = 4'd14;
   localparam logic [STEP_W-1:0] CMD_PUBLISH    = 4'd15;

   typedef struct packed {
      logic              capture;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            var_below;
   } status_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  rate_scale;
      logic [WEIGHT_W-1:0] mean_weight;
      logic [WEIGHT_W-1:0] variance_weight;
      logic [WEIGHT_W-1:0] bias_weight;
      logic [LIMIT_W-1:0]  variance_limit;
      logic [COUNT_W-1:0]  lock_ceiling;
      logic [COUNT_W-1:0]  calibrated_level;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rate_scale:       24'd143864,
      mean_weight:      16'd655,
      variance_weight:  16'd3277,
      bias_weight:      16'd655,
      variance_limit:   24'd2621,
      lock_ceiling:     11'd1024,
      calibrated_level: 11'd128
   };

endpackage

// ===== hdl/gba_dpath.sv =====
// Datapath: shared multiplier, estimator state and result registers.
`timescale 1ns / 1ps
module gba_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  gba_pkg::cmd_type                 cmd,
   output gba_pkg::status_type              status,
   input  gba_pkg::cfg_type                 cfg,
   input  logic [gba_pkg::OP_W-1:0]         in_op,
   input  logic signed [gba_pkg::RAW_W-1:0] in_raw_rate,
   input  logic [gba_pkg::IVL_W-1:0]        in_interval,
   output logic signed [gba_pkg::CORR_W-1:0] out_corrected_rate,
   output logic signed [gba_pkg::HEAD_W-1:0] out_heading,
   output logic                             out_calibrated
);

   localparam int RATE_FULL_W = gba_pkg::PROD_W - gba_pkg::RATE_SHIFT;
   localparam int SQ_FULL_W   = gba_pkg::PROD_W - gba_pkg::FRACTION_BITS;
   localparam int A_EXT_W     = gba_pkg::MUL_A_W - gba_pkg::CORR_W;
   localparam int SQ_HI_W     = gba_pkg::CORR_W - gba_pkg::SQ_SPLIT;

   // Captured item
   logic [gba_pkg::OP_W-1:0]         op_ff;
   logic signed [gba_pkg::RAW_W-1:0] raw_ff;
   logic [gba_pkg::IVL_W-1:0]        ivl_ff;

   // Estimator state
   logic signed [gba_pkg::RATE_W-1:0] last_rate_ff, last_rate_in;
   logic signed [gba_pkg::RATE_W-1:0] bias_ff, bias_in;
   logic signed [gba_pkg::RATE_W-1:0] mean_ff, mean_in;
   logic [gba_pkg::HEAD_W-1:0]        heading_ff, heading_in;
   logic [gba_pkg::VAR_W-1:0]         var_ff, var_in;
   logic [gba_pkg::COUNT_W-1:0]       count_ff, count_in;

   // Working registers
   logic signed [gba_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [gba_pkg::PROD_W-1:0] sq_acc_ff;
   logic [gba_pkg::VAR_W-1:0]         sq_ff, sq_in;

   // Result registers
   logic signed [gba_pkg::CORR_W-1:0] corr_out_ff;
   logic [gba_pkg::HEAD_W-1:0]        head_out_ff;
   logic                              cal_out_ff;

   logic signed [gba_pkg::MUL_A_W-1:0] mul_a;
   logic signed [gba_pkg::MUL_B_W-1:0] mul_b;
   logic                               mul_en;

   logic signed [gba_pkg::CORR_W-1:0]  rate_minus_bias;
   logic signed [gba_pkg::CORR_W-1:0]  rate_minus_mean;
   logic signed [gba_pkg::CORR_W-1:0]  mean_minus_bias;
   logic signed [gba_pkg::VAR_W:0]     sq_minus_var;

   logic [RATE_FULL_W-1:0]                         rate_full;
   logic [RATE_FULL_W-gba_pkg::RATE_W:0]           rate_top;
   logic signed [gba_pkg::PROD_W-1:0]              sq_sum;
   logic [SQ_FULL_W-1:0]                           sq_full;

   // Differences feeding the multiplier and the result
   assign rate_minus_bias = {last_rate_ff[gba_pkg::RATE_W-1], last_rate_ff}
                          - {bias_ff[gba_pkg::RATE_W-1], bias_ff};
   assign rate_minus_mean = {last_rate_ff[gba_pkg::RATE_W-1], last_rate_ff}
                          - {mean_ff[gba_pkg::RATE_W-1], mean_ff};
   assign mean_minus_bias = {mean_ff[gba_pkg::RATE_W-1], mean_ff}
                          - {bias_ff[gba_pkg::RATE_W-1], bias_ff};
   assign sq_minus_var    = {1'b0, sq_ff} - {1'b0, var_ff};

   // Operand select for the shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.step)
         gba_pkg::CMD_MUL_RATE: begin
            mul_a = {{(gba_pkg::MUL_A_W-gba_pkg::SCALE_W){1'b0}}, cfg.rate_scale};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::RAW_W){raw_ff[gba_pkg::RAW_W-1]}}, raw_ff};
         end
         gba_pkg::CMD_MUL_HEAD: begin
            mul_a = {{A_EXT_W{rate_minus_bias[gba_pkg::CORR_W-1]}}, rate_minus_bias};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::IVL_W){1'b0}}, ivl_ff};
         end
         gba_pkg::CMD_MUL_MEAN: begin
            mul_a = {{A_EXT_W{rate_minus_mean[gba_pkg::CORR_W-1]}}, rate_minus_mean};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::WEIGHT_W){1'b0}}, cfg.mean_weight};
         end
         gba_pkg::CMD_MUL_SQH: begin
            // high digit of the deviation, signed
            mul_a = {{A_EXT_W{rate_minus_mean[gba_pkg::CORR_W-1]}}, rate_minus_mean};
            mul_b = {{(gba_pkg::MUL_B_W-SQ_HI_W){rate_minus_mean[gba_pkg::CORR_W-1]}},
                     rate_minus_mean[gba_pkg::CORR_W-1:gba_pkg::SQ_SPLIT]};
         end
         gba_pkg::CMD_MUL_SQL: begin
            // low digit of the deviation, unsigned
            mul_a = {{A_EXT_W{rate_minus_mean[gba_pkg::CORR_W-1]}}, rate_minus_mean};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::SQ_SPLIT){1'b0}},
                     rate_minus_mean[gba_pkg::SQ_SPLIT-1:0]};
         end
         gba_pkg::CMD_MUL_VAR: begin
            mul_a = {{(gba_pkg::MUL_A_W-gba_pkg::VAR_W-1){sq_minus_var[gba_pkg::VAR_W]}},
                     sq_minus_var};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::WEIGHT_W){1'b0}}, cfg.variance_weight};
         end
         gba_pkg::CMD_MUL_BIAS: begin
            mul_a = {{A_EXT_W{mean_minus_bias[gba_pkg::CORR_W-1]}}, mean_minus_bias};
            mul_b = {{(gba_pkg::MUL_B_W-gba_pkg::WEIGHT_W){1'b0}}, cfg.bias_weight};
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Scaled rate with saturation to the rate range
   assign rate_full = prod_ff[gba_pkg::PROD_W-1:gba_pkg::RATE_SHIFT];
   assign rate_top  = rate_full[RATE_FULL_W-1:gba_pkg::RATE_W-1];

   // Squared deviation from its two partial products
   assign sq_sum  = sq_acc_ff + prod_ff;
   assign sq_full = sq_sum[gba_pkg::PROD_W-1:gba_pkg::FRACTION_BITS];
   assign sq_in   = (|sq_full[SQ_FULL_W-1:gba_pkg::VAR_W]) ? '1 : sq_full[gba_pkg::VAR_W-1:0];

   // Next-state of the estimator
   always_comb begin
      last_rate_in = last_rate_ff;
      bias_in      = bias_ff;
      mean_in      = mean_ff;
      heading_in   = heading_ff;
      var_in       = var_ff;
      count_in     = count_ff;
      case (cmd.step)
         gba_pkg::CMD_SET_RATE: begin
            if ((rate_top == '0) || (rate_top == '1)) begin
               last_rate_in = rate_full[gba_pkg::RATE_W-1:0];
            end else begin
               last_rate_in = rate_full[RATE_FULL_W-1] ? {1'b1, {(gba_pkg::RATE_W-1){1'b0}}}
                                                       : {1'b0, {(gba_pkg::RATE_W-1){1'b1}}};
            end
         end
         gba_pkg::CMD_ADD_HEAD: begin
            heading_in = heading_ff
                       + prod_ff[gba_pkg::HEAD_W+gba_pkg::IVL_W-1:gba_pkg::IVL_W];
         end
         gba_pkg::CMD_ADD_MEAN: begin
            mean_in = mean_ff + prod_ff[gba_pkg::RATE_W+gba_pkg::WEIGHT_W-1:gba_pkg::WEIGHT_W];
         end
         gba_pkg::CMD_ADD_VAR: begin
            var_in = var_ff + prod_ff[gba_pkg::VAR_W+gba_pkg::WEIGHT_W-1:gba_pkg::WEIGHT_W];
         end
         gba_pkg::CMD_ADD_BIAS: begin
            bias_in = bias_ff + prod_ff[gba_pkg::RATE_W+gba_pkg::WEIGHT_W-1:gba_pkg::WEIGHT_W];
            if (count_ff < cfg.lock_ceiling) begin
               count_in = count_ff + 1'b1;
            end
         end
         gba_pkg::CMD_CLEAR_HEAD: heading_in = '0;
         default: ;
      endcase
   end

   // Estimator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rate_ff <= '0;
         bias_ff      <= '0;
         mean_ff      <= '0;
         heading_ff   <= '0;
         var_ff       <= '0;
         count_ff     <= '0;
      end else begin
         last_rate_ff <= last_rate_in;
         bias_ff      <= bias_in;
         mean_ff      <= mean_in;
         heading_ff   <= heading_in;
         var_ff       <= var_in;
         count_ff     <= count_in;
      end
   end

   // Item capture, product, squaring and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= in_op;
         raw_ff <= in_raw_rate;
         ivl_ff <= in_interval;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.step == gba_pkg::CMD_MUL_SQL) begin
         sq_acc_ff <= prod_ff <<< gba_pkg::SQ_SPLIT;
      end
      if (cmd.step == gba_pkg::CMD_SUM_SQ) begin
         sq_ff <= sq_in;
      end
      if (cmd.step == gba_pkg::CMD_PUBLISH) begin
         corr_out_ff <= rate_minus_bias;
         head_out_ff <= heading_ff;
         cal_out_ff  <= (count_ff >= cfg.calibrated_level);
      end
   end

   assign status.op        = op_ff;
   assign status.var_below = (var_ff < {{(gba_pkg::VAR_W-gba_pkg::LIMIT_W){1'b0}},
                                         cfg.variance_limit});

   assign out_corrected_rate = corr_out_ff;
   assign out_heading        = head_out_ff;
   assign out_calibrated     = cal_out_ff;

endmodule

// ===== hdl/gba_ctrl.sv =====
// Controller: sequences datapath steps per item and owns both stream handshakes.
`timescale 1ns / 1ps
module gba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  gba_pkg::status_type status,
   output gba_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SET_RATE = 4'd2;
   localparam logic [3:0] S_MUL_HEAD = 4'd3;
   localparam logic [3:0] S_ADD_HEAD = 4'd4;
   localparam logic [3:0] S_MUL_MEAN = 4'd5;
   localparam logic [3:0] S_ADD_MEAN = 4'd6;
   localparam logic [3:0] S_MUL_SQH  = 4'd7;
   localparam logic [3:0] S_MUL_SQL  = 4'd8;
   localparam logic [3:0] S_SUM_SQ   = 4'd9;
   localparam logic [3:0] S_MUL_VAR  = 4'd10;
   localparam logic [3:0] S_ADD_VAR  = 4'd11;
   localparam logic [3:0] S_TEST     = 4'd12;
   localparam logic [3:0] S_ADD_BIAS = 4'd13;
   localparam logic [3:0] S_PUBLISH  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Step sequence and handshake control
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.step     = gba_pkg::CMD_IDLE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op) inside
               gba_pkg::OP_UPDATE, gba_pkg::OP_CALIBRATE: begin
                  cmd.step = gba_pkg::CMD_MUL_RATE;
                  state_in = S_SET_RATE;
               end
               gba_pkg::OP_CLEAR: begin
                  cmd.step = gba_pkg::CMD_CLEAR_HEAD;
                  state_in = S_PUBLISH;
               end
               default: state_in = S_PUBLISH;
            endcase
         end
         S_SET_RATE: begin
            cmd.step = gba_pkg::CMD_SET_RATE;
            state_in = S_MUL_HEAD;
         end
         S_MUL_HEAD: begin
            cmd.step = gba_pkg::CMD_MUL_HEAD;
            state_in = S_ADD_HEAD;
         end
         S_ADD_HEAD: begin
            cmd.step = gba_pkg::CMD_ADD_HEAD;
            state_in = (status.op == gba_pkg::OP_CALIBRATE) ? S_MUL_MEAN : S_PUBLISH;
         end
         S_MUL_MEAN: begin
            cmd.step = gba_pkg::CMD_MUL_MEAN;
            state_in = S_ADD_MEAN;
         end
         S_ADD_MEAN: begin
            cmd.step = gba_pkg::CMD_ADD_MEAN;
            state_in = S_MUL_SQH;
         end
         S_MUL_SQH: begin
            cmd.step = gba_pkg::CMD_MUL_SQH;
            state_in = S_MUL_SQL;
         end
         S_MUL_SQL: begin
            cmd.step = gba_pkg::CMD_MUL_SQL;
            state_in = S_SUM_SQ;
         end
         S_SUM_SQ: begin
            cmd.step = gba_pkg::CMD_SUM_SQ;
            state_in = S_MUL_VAR;
         end
         S_MUL_VAR: begin
            cmd.step = gba_pkg::CMD_MUL_VAR;
            state_in = S_ADD_VAR;
         end
         S_ADD_VAR: begin
            cmd.step = gba_pkg::CMD_ADD_VAR;
            state_in = S_TEST;
         end
         S_TEST: begin
            // bias tracks the mean only while the variance is low
            if (status.var_below) begin
               cmd.step = gba_pkg::CMD_MUL_BIAS;
               state_in = S_ADD_BIAS;
            end else begin
               state_in = S_PUBLISH;
            end
         end
         S_ADD_BIAS: begin
            cmd.step = gba_pkg::CMD_ADD_BIAS;
            state_in = S_PUBLISH;
         end
         S_PUBLISH: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.step     = gba_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/gyro_bias_autocal_heading.sv =====
// Top level: gyro heading integrator with moving-average bias calibration.
//
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   tdata: raw_rate, interval; tuser: op
//  rsp_     out        rsp_tvalid/rsp_tready   tdata: corrected_rate, heading; tuser: calibrated
//  csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// One item at a time through a single shared 38x18 multiplier sequenced by the controller.
// Clear heading and unused ops go straight to the result; update scales and integrates;
// calibrate adds mean, deviation squared and variance steps, plus bias when variance is low.
// Reset is synchronous and clears estimator state and loads register defaults.
// A result waiting on rsp_tready holds the block before its next result is loaded;
// the next transaction is taken while the previous result still waits.
`timescale 1ns / 1ps
module gyro_bias_autocal_heading (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gba_pkg::REQ_DATA_W-1:0]       req_tdata,  // raw_rate, interval
   input  logic [gba_pkg::OP_W-1:0]             req_tuser,  // op
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gba_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // corrected_rate, heading, zero pad
   output logic                                 rsp_tuser,  // calibrated
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gba_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gba_pkg::CSR_DATA_W-1:0]       csr_data
);

   gba_pkg::cfg_type    cfg_ff, cfg_in;
   gba_pkg::cmd_type    cmd;
   gba_pkg::status_type status;

   logic signed [gba_pkg::CORR_W-1:0] corrected_rate;
   logic signed [gba_pkg::HEAD_W-1:0] heading;

   // Register writes, always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gba_pkg::CSR_RATE_SCALE:       cfg_in.rate_scale       = csr_data;
            gba_pkg::CSR_MEAN_WEIGHT:      cfg_in.mean_weight      = csr_data[gba_pkg::WEIGHT_W-1:0];
            gba_pkg::CSR_VARIANCE_WEIGHT:  cfg_in.variance_weight  = csr_data[gba_pkg::WEIGHT_W-1:0];
            gba_pkg::CSR_BIAS_WEIGHT:      cfg_in.bias_weight      = csr_data[gba_pkg::WEIGHT_W-1:0];
            gba_pkg::CSR_VARIANCE_LIMIT:   cfg_in.variance_limit   = csr_data;
            gba_pkg::CSR_LOCK_CEILING:     cfg_in.lock_ceiling     = csr_data[gba_pkg::COUNT_W-1:0];
            gba_pkg::CSR_CALIBRATED_LEVEL: cfg_in.calibrated_level = csr_data[gba_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gba_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Controller
   gba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath
   gba_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg_ff),
      .in_op              (req_tuser),
      .in_raw_rate        (req_tdata[gba_pkg::RAW_W-1:0]),
      .in_interval        (req_tdata[gba_pkg::REQ_DATA_W-1:gba_pkg::RAW_W]),
      .out_corrected_rate (corrected_rate),
      .out_heading        (heading),
      .out_calibrated     (rsp_tuser)
   );

   assign rsp_tdata = {{gba_pkg::RSP_PAD_W{1'b0}}, heading, corrected_rate};

endmodule

// ===== hdl/gba_checker.sv =====
// Port-level checker for the heading block, bound to the top level.
`timescale 1ns / 1ps
module gba_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tuser
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped without a transaction");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // One item at a time: busy right after a request transaction
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous item in progress");

   // No result can appear in the cycle right after a request transaction
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result produced faster than the datapath allows");

endmodule

bind gyro_bias_autocal_heading gba_checker u_gba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/heading_checker.sv =====
// Checker for the gyro heading block: predicts every result and compares it on the fly.
`timescale 1ns / 1ps
module heading_checker
   import gba_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // raw_rate, interval
   input  logic [OP_W-1:0]         req_tuser,   // op
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,   // corrected_rate, heading, zero pad
   input  logic                    rsp_tuser,   // calibrated
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output int                      fail_count,
   output int                      outstanding
);

   typedef struct {
      logic [CORR_W-1:0] corrected;
      logic [HEAD_W-1:0] heading;
      logic              calibrated;
   } estimate_type;

   localparam longint RATE_HI = (64'sd1 <<< (RATE_W - 1)) - 1;
   localparam longint RATE_LO = -(64'sd1 <<< (RATE_W - 1));
   localparam longint VAR_HI  = (64'sd1 <<< VAR_W) - 1;
   localparam longint UNITY   = 64'sd65536;

   // Shadow copy of the registers and the estimator state
   cfg_type                  cfg = CFG_RESET;
   logic signed [RATE_W-1:0] rate_est = '0;
   logic signed [RATE_W-1:0] bias_est = '0;
   logic signed [RATE_W-1:0] mean_est = '0;
   logic [HEAD_W-1:0]        heading_est = '0;
   logic [VAR_W-1:0]         variance_est = '0;
   logic [COUNT_W-1:0]       stable_est = '0;
   estimate_type             heading_queue[$];
   estimate_type             want;
   int                       errors = 0;

   // Moving-average blend with a Q0.16 weight, floor on the product
   function automatic longint ema(input logic [WEIGHT_W-1:0] w, input longint x, input longint y);
      longint wl;
      wl = w;
      return (wl * x + (UNITY - wl) * y) >>> 16;
   endfunction

   // Advances the estimator by one request and returns the result it should produce
   function automatic estimate_type advance_estimator(input logic [OP_W-1:0] op,
                                                      input logic signed [RAW_W-1:0] raw,
                                                      input logic [IVL_W-1:0] ivl);
      longint       raw_l, ivl_l, scale_l, rate_l, bias_l, mean_l, var_l, diff, sq, delta, w;
      estimate_type est;
      raw_l   = raw;
      ivl_l   = ivl;
      scale_l = cfg.rate_scale;
      case (op)
         OP_UPDATE, OP_CALIBRATE: begin
            // scale the sample, saturating on overflow
            rate_l = (raw_l * scale_l) >>> RATE_SHIFT;
            if (rate_l > RATE_HI)
               rate_l = RATE_HI;
            else if (rate_l < RATE_LO)
               rate_l = RATE_LO;
            rate_est = rate_l[RATE_W-1:0];
            // integrate with the bias from before this sample
            bias_l = bias_est;
            delta = ((rate_l - bias_l) * ivl_l) >>> 16;
            heading_est = heading_est + delta[HEAD_W-1:0];
            if (op == OP_CALIBRATE) begin
               mean_l = mean_est;
               mean_l = ema(cfg.mean_weight, rate_l, mean_l);
               mean_est = mean_l[RATE_W-1:0];
               // variance against the new mean
               diff = rate_l - mean_l;
               sq = (diff * diff) >>> FRACTION_BITS;
               if (sq > VAR_HI)
                  sq = VAR_HI;
               w = cfg.variance_weight;
               var_l = variance_est;
               var_l = (w * sq + (UNITY - w) * var_l) >>> 16;
               variance_est = var_l[VAR_W-1:0];
               // quiet enough: track the mean and count toward lock
               if (variance_est < cfg.variance_limit) begin
                  bias_l = ema(cfg.bias_weight, mean_l, bias_l);
                  bias_est = bias_l[RATE_W-1:0];
                  if (stable_est < cfg.lock_ceiling)
                     stable_est = stable_est + 1'b1;
               end
            end
         end
         OP_CLEAR: heading_est = '0;
         default: ;
      endcase
      rate_l = rate_est;
      bias_l = bias_est;
      diff = rate_l - bias_l;
      est.corrected  = diff[CORR_W-1:0];
      est.heading    = heading_est;
      est.calibrated = (stable_est >= cfg.calibrated_level);
      return est;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint exp_v);
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, field, got, exp_v);
      errors++;
   endtask

   // Result before request so a queue never matches a transaction taken on the same edge
   always @(posedge clock) begin
      if (reset) begin
         cfg          = CFG_RESET;
         rate_est     = '0;
         bias_est     = '0;
         mean_est     = '0;
         heading_est  = '0;
         variance_est = '0;
         stable_est   = '0;
         heading_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (heading_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = heading_queue.pop_front();
               if (rsp_tdata[CORR_W-1:0] !== want.corrected)
                  report_mismatch("corrected_rate", rsp_tdata[CORR_W-1:0], want.corrected);
               if (rsp_tdata[CORR_W+HEAD_W-1:CORR_W] !== want.heading)
                  report_mismatch("heading", rsp_tdata[CORR_W+HEAD_W-1:CORR_W], want.heading);
               if (rsp_tdata[RSP_DATA_W-1:CORR_W+HEAD_W] !== '0)
                  report_mismatch("pad", rsp_tdata[RSP_DATA_W-1:CORR_W+HEAD_W], 0);
               if (rsp_tuser !== want.calibrated)
                  report_mismatch("calibrated", rsp_tuser, want.calibrated);
            end
         end
         if (req_tvalid && req_tready)
            heading_queue.push_back(advance_estimator(req_tuser, req_tdata[RAW_W-1:0],
                                                      req_tdata[REQ_DATA_W-1:RAW_W]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RATE_SCALE:       cfg.rate_scale       = csr_data[SCALE_W-1:0];
               CSR_MEAN_WEIGHT:      cfg.mean_weight      = csr_data[WEIGHT_W-1:0];
               CSR_VARIANCE_WEIGHT:  cfg.variance_weight  = csr_data[WEIGHT_W-1:0];
               CSR_BIAS_WEIGHT:      cfg.bias_weight      = csr_data[WEIGHT_W-1:0];
               CSR_VARIANCE_LIMIT:   cfg.variance_limit   = csr_data[LIMIT_W-1:0];
               CSR_LOCK_CEILING:     cfg.lock_ceiling     = csr_data[COUNT_W-1:0];
               CSR_CALIBRATED_LEVEL: cfg.calibrated_level = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count  <= errors;
      outstanding <= heading_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the heading block regression: stimulus, register phases, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
   import gba_pkg::*;

   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 24;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int IDLE_PERCENT    = 32;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;  // raw_rate, interval
   logic [OP_W-1:0]        req_tuser  = '0;  // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // corrected_rate, heading, zero pad
   logic                   rsp_tuser;        // calibrated
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;
   bit gaps_on      = 1'b1;
   int rate_base    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   gyro_bias_autocal_heading dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   heading_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gyro_bias_autocal_heading regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One sample transaction, with random idle cycles ahead of it
   task automatic send_sample(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                              input logic [IVL_W-1:0] ivl);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ivl, raw};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [WEIGHT_W-1:0] mw,
                             input logic [WEIGHT_W-1:0] vw, input logic [WEIGHT_W-1:0] bw,
                             input logic [LIMIT_W-1:0] limit, input logic [COUNT_W-1:0] ceiling,
                             input logic [COUNT_W-1:0] level);
      write_reg(CSR_RATE_SCALE, CSR_DATA_W'(scale));
      write_reg(CSR_MEAN_WEIGHT, CSR_DATA_W'(mw));
      write_reg(CSR_VARIANCE_WEIGHT, CSR_DATA_W'(vw));
      write_reg(CSR_BIAS_WEIGHT, CSR_DATA_W'(bw));
      write_reg(CSR_VARIANCE_LIMIT, CSR_DATA_W'(limit));
      write_reg(CSR_LOCK_CEILING, CSR_DATA_W'(ceiling));
      write_reg(CSR_CALIBRATED_LEVEL, CSR_DATA_W'(level));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending, wait for every result and let the datapath settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register value: extremes, the reset value or anything in range
   function automatic int unsigned pick_setting(input int unsigned top, input int unsigned dflt);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      else if (r == 1)
         return top;
      else if (r < 6)
         return dflt;
      return $urandom_range(0, top);
   endfunction

   // Counter levels: mostly small so lock and calibrated are reached within a phase
   function automatic int unsigned pick_count();
      int unsigned r;
      r = $urandom_range(0, 5);
      if (r == 0)
         return 0;
      else if (r == 1)
         return 2047;
      else if (r == 2)
         return $urandom_range(0, 2047);
      return $urandom_range(1, 200);
   endfunction

   // Mostly steady calibration runs around a base rate, the rest noise and other ops
   task automatic random_sample();
      int unsigned      kind;
      int unsigned      span;
      logic [OP_W-1:0]  op;
      logic [RAW_W-1:0] raw;
      logic [IVL_W-1:0] ivl;
      kind = $urandom_range(0, 99);
      raw  = RAW_W'($urandom);
      op   = OP_CALIBRATE;
      if ($urandom_range(0, 99) < 3)
         rate_base = int'($urandom_range(0, 400)) - 200;
      if (kind < 55)
         raw = RAW_W'(rate_base + int'($urandom_range(0, 16)) - 8);
      else if (kind < 75)
         op = OP_UPDATE;
      else if (kind < 85)
         op = OP_CALIBRATE;
      else if (kind < 93)
         op = OP_CLEAR;
      else
         op = OP_RESERVED;
      span = $urandom_range(0, 9);
      if (span < 7)
         ivl = IVL_W'($urandom_range(0, 6554));
      else if (span < 9)
         ivl = IVL_W'($urandom);
      else
         ivl = $urandom_range(0, 1) ? '1 : '0;
      send_sample(op, raw, ivl);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: field extremes, clear, unused op, quiet calibration
      send_sample(OP_UPDATE, 16'sd0, 16'd0);
      send_sample(OP_UPDATE, 16'sh7FFF, 16'hFFFF);
      send_sample(OP_UPDATE, 16'sh8000, 16'hFFFF);
      send_sample(OP_UPDATE, 16'hFFFF, 16'd1);
      send_sample(OP_CLEAR, 16'hA5A5, 16'h5A5A);
      send_sample(OP_RESERVED, 16'd1234, 16'd999);
      repeat (6) send_sample(OP_CALIBRATE, 16'd0, 16'd100);
      drain();

      // Full scale and full weights: rate saturates both ways
      set_config('1, '1, '1, '1, '1, 11'd2047, 11'd0);
      send_sample(OP_CALIBRATE, 16'sh7FFF, 16'hFFFF);
      send_sample(OP_CALIBRATE, 16'sh8000, 16'hFFFF);
      send_sample(OP_CALIBRATE, 16'sh8000, 16'd0);
      send_sample(OP_UPDATE, 16'd1, 16'hFFFF);
      drain();

      // Ceiling lowered under the current count, zero scale and zero weights
      set_config('0, '0, '0, '0, '1, 11'd2, 11'd2047);
      send_sample(OP_CALIBRATE, 16'd300, 16'd500);
      send_sample(OP_CALIBRATE, -16'sd300, 16'd500);
      send_sample(OP_UPDATE, 16'd5, 16'd5);
      send_sample(OP_CLEAR, 16'd0, 16'd0);
      drain();

      // Random phases, the first one without any idle cycles
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         gaps_on = (phase != 0);
         if (phase == 0)
            set_config(CFG_RESET.rate_scale, CFG_RESET.mean_weight, CFG_RESET.variance_weight,
                       CFG_RESET.bias_weight, CFG_RESET.variance_limit, 11'd100, 11'd40);
         else
            set_config(SCALE_W'(pick_setting(24'hFFFFFF, CFG_RESET.rate_scale)),
                       WEIGHT_W'(pick_setting(16'hFFFF, CFG_RESET.mean_weight)),
                       WEIGHT_W'(pick_setting(16'hFFFF, CFG_RESET.variance_weight)),
                       WEIGHT_W'(pick_setting(16'hFFFF, CFG_RESET.bias_weight)),
                       LIMIT_W'(pick_setting(24'hFFFFFF, CFG_RESET.variance_limit)),
                       COUNT_W'(pick_count()), COUNT_W'(pick_count()));
         rate_base = int'($urandom_range(0, 400)) - 200;
         repeat (ITEMS_PER_PHASE) random_sample();
         drain();
      end

      if (fail_count == 0)
         $display("gyro_bias_autocal_heading regression: pass");
      else
         $display("gyro_bias_autocal_heading regression: fail");
      $finish;
   end

endmodule
